// ----- src/ivalloc_pkg.sv -----
// ----------------------------------------------------------------------------
// ivalloc_pkg
// Shared types, constants and helpers for the interrupt vector allocator.
// ----------------------------------------------------------------------------
package ivalloc_pkg;

   localparam int VECTOR_COUNT_DEF = 256;
   localparam int PIC_BASE_DEF     = 32;
   localparam int APIC_BASE_DEF    = 48;

   // owner entry: bit 9 used, bit 8 msi mark, bits 7..0 pin
   localparam int OWNER_W        = 10;
   localparam int OWNER_USED_BIT = 9;

   localparam int PRIO_TOP  = 'h7F;
   localparam int PRIO_STEP = 'h10;
   localparam int PRIO_MIN  = 1;
   localparam int PRIO_MAX  = 5;

   typedef enum logic {
      OP_ASSIGN  = 1'b0,
      OP_RELEASE = 1'b1
   } op_type;

   typedef struct packed {
      logic [7:0] vector;
      logic       is_new;
      logic       failed;
   } res_type;

   // top of the downward allocation scan for a requested priority
   function automatic logic [6:0] prio_top(input logic [2:0] prio);
      logic [2:0] p;
      p = prio;
      if (p < 3'(PRIO_MIN)) p = 3'(PRIO_MIN);
      if (p > 3'(PRIO_MAX)) p = 3'(PRIO_MAX);
      return 7'(PRIO_TOP - PRIO_STEP * (int'(p) - 1));
   endfunction

endpackage

// ----- src/ivalloc_ram.sv -----
// ----------------------------------------------------------------------------
// ivalloc_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module ivalloc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/interrupt_vector_allocator.sv -----
// ----------------------------------------------------------------------------
// interrupt_vector_allocator
// Hands out interrupt vectors from an owner table kept in block RAM.
// ----------------------------------------------------------------------------
// After reset the owner table is cleared one entry a cycle, while
// req_tready stays low. A release, or any assignment in PIC mode, goes
// from ST_IDLE straight to ST_RESP, which loads the output register once it
// is free. In APIC mode a non-MSI assignment first walks the whole table
// upward looking for a vector the pin already owns, then, like an MSI
// assignment, walks downward from the priority top to APIC_BASE for a free
// entry. Both walks are set by the single table read port: one entry per
// cycle. A finished result sits in the output register, so the next request
// is taken while it waits.
module interrupt_vector_allocator #(
   parameter int VECTOR_COUNT = ivalloc_pkg::VECTOR_COUNT_DEF,
   parameter int PIC_BASE     = ivalloc_pkg::PIC_BASE_DEF,
   parameter int APIC_BASE    = ivalloc_pkg::APIC_BASE_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // configuration
   input  logic        csr_wr_en,
   input  logic        csr_wr_data,   // pic_mode
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,     // irq_pin[7:0], is_msi[8], priority_req[11:9],
                                      // release_vector[19:12], zero[23:20]
   input  logic        req_tuser,     // opcode
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata      // vector[7:0], is_new[8], failed[9], zero[15:10]
);
   import ivalloc_pkg::*;

   localparam int AW = $clog2(VECTOR_COUNT);

   typedef enum logic [4:0] {
      ST_CLEAR = 5'b00001,
      ST_IDLE  = 5'b00010,
      ST_REUSE = 5'b00100,
      ST_ALLOC = 5'b01000,
      ST_RESP  = 5'b10000
   } state_type;

   state_type           state_ff, state_in;
   logic [AW-1:0]       scan_ff, scan_in;
   logic                issue_on_ff, issue_on_in;
   logic [AW-1:0]       cand_ff, cand_in;
   logic                cand_vld_ff, cand_vld_in;
   logic [OWNER_W-1:0]  tag_ff, tag_in;
   logic [AW-1:0]       top_ff, top_in;
   logic                top_ok_ff, top_ok_in;
   res_type             res_ff, res_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [15:0]         rsp_data_ff, rsp_data_in;
   logic                pic_mode_ff;

   logic                ram_we;
   logic [AW-1:0]       ram_waddr;
   logic [OWNER_W-1:0]  ram_wdata;
   logic [AW-1:0]       ram_raddr;
   logic [OWNER_W-1:0]  ram_rdata;

   logic [7:0]          req_pin;
   logic                req_msi;
   logic [2:0]          req_prio;
   logic [7:0]          req_rel;
   logic [8:0]          pic_vec;
   logic [6:0]          raw_top;
   logic [8:0]          top_clamped;

   assign req_pin  = req_tdata[7:0];
   assign req_msi  = req_tdata[8];
   assign req_prio = req_tdata[11:9];
   assign req_rel  = req_tdata[19:12];

   assign pic_vec = {1'b0, req_pin} + 9'(PIC_BASE);
   assign raw_top = prio_top(req_prio);

   always_comb begin
      if ({2'b00, raw_top} > 9'(VECTOR_COUNT - 1)) begin
         top_clamped = 9'(VECTOR_COUNT - 1);
      end else begin
         top_clamped = {2'b00, raw_top};
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   ivalloc_ram #(
      .WIDTH(OWNER_W),
      .DEPTH(VECTOR_COUNT)
   ) u_owner_ram (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_waddr),
      .wr_data(ram_wdata),
      .rd_addr(ram_raddr),
      .rd_data(ram_rdata)
   );

   always_comb begin
      state_in     = state_ff;
      scan_in      = scan_ff;
      issue_on_in  = issue_on_ff;
      cand_in      = cand_ff;
      cand_vld_in  = cand_vld_ff;
      tag_in       = tag_ff;
      top_in       = top_ff;
      top_ok_in    = top_ok_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      ram_we       = 1'b0;
      ram_waddr    = scan_ff;
      ram_wdata    = '0;
      ram_raddr    = scan_ff;

      unique case (state_ff)
         ST_CLEAR: begin
            ram_we = 1'b1;
            if (scan_ff == AW'(VECTOR_COUNT - 1)) begin
               scan_in  = '0;
               state_in = ST_IDLE;
            end else begin
               scan_in = scan_ff + 1'b1;
            end
         end

         ST_IDLE: begin
            if (req_tvalid) begin
               tag_in      = {1'b1, req_msi, req_pin};
               top_in      = AW'(top_clamped);
               top_ok_in   = (top_clamped >= 9'(APIC_BASE));
               cand_vld_in = 1'b0;
               issue_on_in = 1'b0;
               res_in      = '{vector: 8'h00, is_new: 1'b0, failed: 1'b0};
               if (req_tuser == OP_RELEASE) begin
                  if ({1'b0, req_rel} < 9'(VECTOR_COUNT)) begin
                     ram_we    = 1'b1;
                     ram_waddr = AW'(req_rel);
                  end
                  state_in = ST_RESP;
               end else if (pic_mode_ff) begin
                  if (pic_vec > 9'(VECTOR_COUNT - 1)) begin
                     res_in.failed = 1'b1;
                  end else begin
                     res_in.vector = pic_vec[7:0];
                  end
                  state_in = ST_RESP;
               end else if (!req_msi) begin
                  scan_in     = '0;
                  issue_on_in = 1'b1;
                  state_in    = ST_REUSE;
               end else if (top_clamped >= 9'(APIC_BASE)) begin
                  scan_in     = AW'(top_clamped);
                  issue_on_in = 1'b1;
                  state_in    = ST_ALLOC;
               end else begin
                  res_in.failed = 1'b1;
                  state_in      = ST_RESP;
               end
            end
         end

         ST_REUSE: begin
            // one read issued per cycle, its data checked in the cycle after
            cand_vld_in = issue_on_ff;
            cand_in     = scan_ff;
            if (issue_on_ff) begin
               if (scan_ff == AW'(VECTOR_COUNT - 1)) begin
                  issue_on_in = 1'b0;
               end else begin
                  scan_in = scan_ff + 1'b1;
               end
            end
            if (cand_vld_ff) begin
               if (ram_rdata == tag_ff) begin
                  res_in      = '{vector: 8'(cand_ff), is_new: 1'b0, failed: 1'b0};
                  issue_on_in = 1'b0;
                  cand_vld_in = 1'b0;
                  state_in    = ST_RESP;
               end else if (cand_ff == AW'(VECTOR_COUNT - 1)) begin
                  cand_vld_in = 1'b0;
                  if (top_ok_ff) begin
                     scan_in     = top_ff;
                     issue_on_in = 1'b1;
                     state_in    = ST_ALLOC;
                  end else begin
                     res_in      = '{vector: 8'h00, is_new: 1'b0, failed: 1'b1};
                     issue_on_in = 1'b0;
                     state_in    = ST_RESP;
                  end
               end
            end
         end

         ST_ALLOC: begin
            cand_vld_in = issue_on_ff;
            cand_in     = scan_ff;
            if (issue_on_ff) begin
               if (scan_ff == AW'(APIC_BASE)) begin
                  issue_on_in = 1'b0;
               end else begin
                  scan_in = scan_ff - 1'b1;
               end
            end
            if (cand_vld_ff) begin
               if (!ram_rdata[OWNER_USED_BIT]) begin
                  ram_we      = 1'b1;
                  ram_waddr   = cand_ff;
                  ram_wdata   = tag_ff;
                  res_in      = '{vector: 8'(cand_ff), is_new: 1'b1, failed: 1'b0};
                  issue_on_in = 1'b0;
                  cand_vld_in = 1'b0;
                  state_in    = ST_RESP;
               end else if (cand_ff == AW'(APIC_BASE)) begin
                  res_in      = '{vector: 8'h00, is_new: 1'b0, failed: 1'b1};
                  issue_on_in = 1'b0;
                  cand_vld_in = 1'b0;
                  state_in    = ST_RESP;
               end
            end
         end

         ST_RESP: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {6'b000000, res_ff.failed, res_ff.is_new, res_ff.vector};
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_CLEAR;
            scan_in  = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         scan_ff      <= '0;
         issue_on_ff  <= 1'b0;
         cand_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pic_mode_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         scan_ff      <= scan_in;
         issue_on_ff  <= issue_on_in;
         cand_vld_ff  <= cand_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            pic_mode_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      cand_ff     <= cand_in;
      tag_ff      <= tag_in;
      top_ff      <= top_in;
      top_ok_ff   <= top_ok_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

// ----- src/ivalloc_checker.sv -----
// ----------------------------------------------------------------------------
// ivalloc_checker
// Port-level checks for the interrupt vector allocator, bound to the top.
// ----------------------------------------------------------------------------
module ivalloc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata
);

   // table clearing keeps requests out right after reset
   assert property (@(posedge clock) reset |=> !rsp_tvalid && !req_tready)
      else $error("busy state not held after reset");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response beat changed");

   // a beat never claims a fresh entry and fails at once
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[8] && rsp_tdata[9]))
      else $error("is_new and failed both set");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[9] |-> rsp_tdata[7:0] == 8'h00 && rsp_tdata[15:10] == 6'h00)
      else $error("failed beat carries a vector");

endmodule

bind interrupt_vector_allocator ivalloc_checker u_ivalloc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_tvalid(req_tvalid),
   .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata (rsp_tdata)
);
